@@ rtl/lbfs_pkg.sv @@
// shared types, constants and register codes of the led blink and fade sequencer
package lbfs_pkg;

  // fixed field widths
  localparam int LEVEL_BITS    = 8;
  localparam int FUNC_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int BLINK_MS_W    = 16;
  localparam int FADE_MS_W     = 32;
  localparam int TIME_BITS_DEF = 32;

  // register reset values
  localparam logic [BLINK_MS_W-1:0] ON_MS_RST       = 16'd500;
  localparam logic [BLINK_MS_W-1:0] OFF_MS_RST      = 16'd500;
  localparam logic [LEVEL_BITS-1:0] BLINK_LEVEL_RST = 8'd255;
  localparam logic [LEVEL_BITS-1:0] FADE_START_RST  = 8'd0;
  localparam logic [LEVEL_BITS-1:0] FADE_END_RST    = 8'd255;
  localparam logic [FADE_MS_W-1:0]  FADE_MS_RST     = 32'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_ON_MS       = 3'd1,
    REG_OFF_MS      = 3'd2,
    REG_BLINK_LEVEL = 3'd3,
    REG_FADE_START  = 3'd4,
    REG_FADE_END    = 3'd5,
    REG_FADE_MS     = 3'd6
  } cfg_reg_t;

  // pattern modes
  typedef enum logic [1:0] {
    MODE_HOLD     = 2'd0,
    MODE_BLINK    = 2'd1,
    MODE_FADE     = 2'd2,
    MODE_PINGPONG = 2'd3
  } mode_t;

  // request functions
  typedef enum logic [FUNC_W-1:0] {
    FUNC_EVAL = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_SET  = 2'd2
  } func_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic eval;
    logic mul;
    logic check;
    logic load_out;
  } lbfs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_step;
  } lbfs_stat_t;

endpackage

@@ rtl/lbfs_if.sv @@
// request and response channel interfaces of the led blink and fade sequencer
interface lbfs_req_if import lbfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [LEVEL_BITS-1:0] set_level;

  modport source (output valid, func, set_level, input ready);
  modport sink   (input valid, func, set_level, output ready);
endinterface

interface lbfs_rsp_if import lbfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic                  changed;

  modport source (output valid, level, changed, input ready);
  modport sink   (input valid, level, changed, output ready);
endinterface

@@ rtl/lbfs_datapath.sv @@
// datapath: configuration registers, level and clock state, fade step test
module lbfs_datapath import lbfs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lbfs_cmd_t             cmd,
  output lbfs_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     req_func,
  input  logic [LEVEL_BITS-1:0] req_set_level,
  output logic [LEVEL_BITS-1:0] rsp_level,
  output logic                  rsp_changed
);

  localparam int INC_W  = TIME_BITS + 1;
  localparam int PROD_W = INC_W + LEVEL_BITS;
  localparam int CMP_W  = (PROD_W > FADE_MS_W) ? PROD_W : FADE_MS_W;

  // configuration
  mode_t                  mode;
  logic [BLINK_MS_W-1:0]  on_ms;
  logic [BLINK_MS_W-1:0]  off_ms;
  logic [LEVEL_BITS-1:0]  blink_level;
  logic [LEVEL_BITS-1:0]  fade_start;
  logic [LEVEL_BITS-1:0]  fade_end;
  logic [FADE_MS_W-1:0]   fade_ms;

  // block state
  logic [LEVEL_BITS-1:0]  cur_level;
  logic [LEVEL_BITS-1:0]  last_level;
  logic [TIME_BITS-1:0]   now_ms;
  logic [TIME_BITS-1:0]   change_stamp;

  // request and working registers
  logic [FUNC_W-1:0]      func_q;
  logic [LEVEL_BITS-1:0]  set_level_q;
  logic                   wrote;
  logic                   step_up;
  logic [LEVEL_BITS-1:0]  aspan;
  logic [INC_W-1:0]       el_inc;
  logic [PROD_W-1:0]      product;

  // evaluation results
  logic [TIME_BITS-1:0]   elapsed;
  logic                   delta_one;
  logic                   went_up;
  logic                   fwd;
  logic [LEVEL_BITS-1:0]  from_lvl;
  logic [LEVEL_BITS-1:0]  to_lvl;
  logic                   lvl_write;
  logic [LEVEL_BITS-1:0]  lvl_value;
  logic                   stamp_write;
  logic                   tick;
  logic                   need_step;
  logic                   step_go;
  logic [LEVEL_BITS-1:0]  step_value;

  assign elapsed = now_ms - change_stamp;

  // signed level difference of plus or minus one
  assign delta_one = ({1'b0, cur_level} == {1'b0, last_level} + {{LEVEL_BITS{1'b0}}, 1'b1}) ||
                     ({1'b0, last_level} == {1'b0, cur_level} + {{LEVEL_BITS{1'b0}}, 1'b1});
  assign went_up   = cur_level > last_level;
  assign fwd       = fade_end > fade_start;

  // fade direction, ping-pong turns round at the ends
  always_comb begin
    from_lvl = fade_start;
    to_lvl   = fade_end;
    if (mode == MODE_PINGPONG && delta_one) begin
      if ((went_up == fwd) ? (cur_level == fade_end) : (cur_level != fade_start)) begin
        from_lvl = fade_end;
        to_lvl   = fade_start;
      end
    end
  end

  // decision for one request
  always_comb begin
    lvl_write   = 1'b0;
    lvl_value   = cur_level;
    stamp_write = 1'b0;
    tick        = 1'b0;
    need_step   = 1'b0;
    case (func_q)
      FUNC_EVAL: begin
        case (mode)
          MODE_BLINK: begin
            if (cur_level == '0) begin
              if (elapsed >= TIME_BITS'(off_ms)) begin
                lvl_write   = 1'b1;
                lvl_value   = blink_level;
                stamp_write = 1'b1;
              end
            end else if (elapsed >= TIME_BITS'(on_ms)) begin
              lvl_write   = 1'b1;
              lvl_value   = '0;
              stamp_write = 1'b1;
            end
          end
          MODE_FADE, MODE_PINGPONG: begin
            if (!delta_one && cur_level != from_lvl) begin
              lvl_write = 1'b1;
              lvl_value = from_lvl;
            end else if (!(delta_one && cur_level == to_lvl) && from_lvl != to_lvl) begin
              need_step = 1'b1;
            end
          end
          default: ;
        endcase
      end
      FUNC_TICK: tick = 1'b1;
      FUNC_SET: begin
        lvl_write = 1'b1;
        lvl_value = set_level_q;
      end
      default: ;
    endcase
  end

  assign stat.need_step = need_step;

  // step test: elapsed >= fade_ms / span  <=>  fade_ms < span * (elapsed + 1)
  assign step_go    = CMP_W'(fade_ms) < CMP_W'(product);
  assign step_value = step_up ? cur_level + {{(LEVEL_BITS-1){1'b0}}, 1'b1}
                              : cur_level - {{(LEVEL_BITS-1){1'b0}}, 1'b1};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HOLD;
      on_ms       <= ON_MS_RST;
      off_ms      <= OFF_MS_RST;
      blink_level <= BLINK_LEVEL_RST;
      fade_start  <= FADE_START_RST;
      fade_end    <= FADE_END_RST;
      fade_ms     <= FADE_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode        <= mode_t'(cfg_data[1:0]);
        REG_ON_MS:       on_ms       <= cfg_data[BLINK_MS_W-1:0];
        REG_OFF_MS:      off_ms      <= cfg_data[BLINK_MS_W-1:0];
        REG_BLINK_LEVEL: blink_level <= cfg_data[LEVEL_BITS-1:0];
        REG_FADE_START:  fade_start  <= cfg_data[LEVEL_BITS-1:0];
        REG_FADE_END:    fade_end    <= cfg_data[LEVEL_BITS-1:0];
        REG_FADE_MS:     fade_ms     <= cfg_data[FADE_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // level, clock and stamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level    <= '0;
      last_level   <= '0;
      now_ms       <= '0;
      change_stamp <= '0;
      wrote        <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        wrote <= 1'b0;
      end
      if (cmd.eval) begin
        if (lvl_write) begin
          last_level <= cur_level;
          cur_level  <= lvl_value;
          wrote      <= 1'b1;
        end
        if (stamp_write) begin
          change_stamp <= now_ms;
        end
        if (tick) begin
          now_ms <= now_ms + {{(TIME_BITS-1){1'b0}}, 1'b1};
        end
      end
      if (cmd.check && step_go) begin
        last_level   <= cur_level;
        cur_level    <= step_value;
        change_stamp <= now_ms;
        wrote        <= 1'b1;
      end
    end
  end

  // request capture, step operands, product and response payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q      <= req_func;
      set_level_q <= req_set_level;
    end
    if (cmd.eval) begin
      step_up <= to_lvl > from_lvl;
      aspan   <= (to_lvl > from_lvl) ? to_lvl - from_lvl : from_lvl - to_lvl;
      el_inc  <= {1'b0, elapsed} + {{TIME_BITS{1'b0}}, 1'b1};
    end
    if (cmd.mul) begin
      product <= el_inc * aspan;
    end
    if (cmd.load_out) begin
      rsp_level   <= cur_level;
      rsp_changed <= wrote;
    end
  end

endmodule

@@ rtl/lbfs_ctrl.sv @@
// controller: request sequencing and response register handshake
module lbfs_ctrl import lbfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  lbfs_stat_t stat,
  output lbfs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_MUL   = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // commands
  assign req_ready     = (state == S_IDLE);
  assign cmd.load_item = (state == S_IDLE) && req_valid;
  assign cmd.eval      = (state == S_EVAL);
  assign cmd.mul       = (state == S_MUL);
  assign cmd.check     = (state == S_CHECK);
  assign cmd.load_out  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_valid) state_next = S_EVAL;
      S_EVAL:  state_next = stat.need_step ? S_MUL : S_DONE;
      S_MUL:   state_next = S_CHECK;
      S_CHECK: state_next = S_DONE;
      S_DONE:  if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/led_blink_and_fade_sequencer.sv @@
// top level of the led blink and fade sequencer
//
// Holds an 8-bit LED duty level and steps it through hold, blink, one-way
// fade or ping-pong fade patterns. Requests arrive on req (func, set_level):
// evaluate the pattern, advance the millisecond clock by one, or set the
// level directly. Each request gives exactly one response on rsp carrying
// the level after the request and whether the request wrote it.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, which the block does not enforce.
// A request is taken in idle and evaluated in the evaluate state; a fade
// request that runs the step test then passes the multiply and compare
// states. The response register is loaded from the done state once it is
// free. One request is in flight at a time: the next request is taken
// only after the response register has been loaded.
// The response register lets the block take the next request while a
// response waits; a stalled receiver holds the following result in its
// final state until the register frees. Reset clears the level, previous
// level, clock and change stamp and loads the register defaults.
module led_blink_and_fade_sequencer import lbfs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lbfs_req_if.sink              req,
  lbfs_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lbfs_cmd_t  cmd;
  lbfs_stat_t stat;

  // sequencing
  lbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // level, clock and step datapath
  lbfs_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_func      (req.func),
    .req_set_level (req.set_level),
    .rsp_level     (rsp.level),
    .rsp_changed   (rsp.changed)
  );

`ifndef SYNTHESIS
  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  // response register never overwritten while a response waits
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten");

  // step multiply always followed by its compare
  assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.check)
    else $error("fade step compare skipped");
`endif

endmodule

@@ tb/sv/tb_led_blink_and_fade_sequencer.sv @@
// self-checking testbench of the led blink and fade sequencer
module tb_led_blink_and_fade_sequencer;
  import lbfs_pkg::*;

  // encoding the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [LEVEL_BITS-1:0] set_level;
  } led_req_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  changed;
  } led_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbfs_req_if req_bus ();
  lbfs_rsp_if rsp_bus ();

  led_blink_and_fade_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted led state and register copies
  logic [LEVEL_BITS-1:0] led_cur, led_prev;
  logic [31:0]           ms_now, ms_stamp;
  logic                  led_wrote;
  mode_t                 r_mode;
  logic [15:0]           r_on_ms, r_off_ms;
  logic [7:0]            r_blink_level, r_fade_start, r_fade_end;
  logic [31:0]           r_fade_ms;

  led_req_t led_pending[$];
  led_rsp_t led_expect[$];
  int queued_total = 0;
  int checked_total = 0;
  int errors = 0;
  int settings = 0;
  int level_writes = 0;
  int cycles = 0;
  int src_idle_max = 0;
  int snk_idle_max = 0;

  function void write_led(logic [LEVEL_BITS-1:0] v);
    led_prev  = led_cur;
    led_cur   = v;
    led_wrote = 1'b1;
  endfunction

  // one fade step test from one end toward the other
  function void fade_toward(logic [7:0] from, logic [7:0] to);
    int cur_i, prev_i, from_i, to_i, delta, span;
    logic [31:0] aspan, interval;
    cur_i  = led_cur;
    prev_i = led_prev;
    from_i = from;
    to_i   = to;
    delta  = cur_i - prev_i;
    span   = to_i - from_i;
    if (delta == 1 || delta == -1) begin
      if (led_cur == to) return;
    end else if (led_cur != from) begin
      write_led(from);
      return;
    end
    // equal ends never step
    if (span == 0) return;
    aspan    = (span > 0) ? span : -span;
    interval = r_fade_ms / aspan;
    if (ms_now - ms_stamp >= interval) begin
      write_led((span > 0) ? led_cur + 8'd1 : led_cur - 8'd1);
      ms_stamp = ms_now;
    end
  endfunction

  // pick the direction of a ping-pong fade from the last step
  function void pingpong_step();
    int cur_i, prev_i, delta, s_i, e_i;
    logic rising, forward;
    cur_i   = led_cur;
    prev_i  = led_prev;
    s_i     = r_fade_start;
    e_i     = r_fade_end;
    delta   = cur_i - prev_i;
    rising  = delta > 0;
    forward = (e_i - s_i) > 0;
    if (delta != 1 && delta != -1) fade_toward(r_fade_start, r_fade_end);
    else if (rising == forward) begin
      if (led_cur == r_fade_end) fade_toward(r_fade_end, r_fade_start);
      else fade_toward(r_fade_start, r_fade_end);
    end else if (led_cur == r_fade_start) fade_toward(r_fade_start, r_fade_end);
    else fade_toward(r_fade_end, r_fade_start);
  endfunction

  // expected response of one request
  function led_rsp_t predict_led(led_req_t r);
    led_rsp_t res;
    led_wrote = 1'b0;
    case (r.func)
      FUNC_EVAL: begin
        case (r_mode)
          MODE_BLINK: begin
            if (led_cur == 0) begin
              if (ms_now - ms_stamp >= {16'd0, r_off_ms}) begin
                write_led(r_blink_level);
                ms_stamp = ms_now;
              end
            end else if (ms_now - ms_stamp >= {16'd0, r_on_ms}) begin
              write_led('0);
              ms_stamp = ms_now;
            end
          end
          MODE_FADE:     fade_toward(r_fade_start, r_fade_end);
          MODE_PINGPONG: pingpong_step();
          default: ;
        endcase
      end
      FUNC_TICK: ms_now = ms_now + 32'd1;
      FUNC_SET:  write_led(r.set_level);
      default: ;
    endcase
    res.level   = led_cur;
    res.changed = led_wrote;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : request_driver
    led_req_t nxt;
    led_rsp_t res;
    int src_gap;
    if (rst) begin
      req_bus.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        res = predict_led({req_bus.func, req_bus.set_level});
        if (res.changed) level_writes++;
        led_expect.push_back(res);
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_bus.valid <= 1'b0;
        end else if (led_pending.size() > 0) begin
          nxt = led_pending.pop_front();
          req_bus.func      <= nxt.func;
          req_bus.set_level <= nxt.set_level;
          req_bus.valid     <= 1'b1;
          src_gap = $urandom_range(0, src_idle_max);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin : response_monitor
    led_rsp_t want;
    int snk_gap;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (led_expect.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t unexpected response level %0d changed %0b", $time,
                     rsp_bus.level, rsp_bus.changed);
        end else begin
          want = led_expect.pop_front();
          if (rsp_bus.level !== want.level) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t level expected %0d actual %0d", $time, want.level, rsp_bus.level);
          end
          if (rsp_bus.changed !== want.changed) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t changed expected %0b actual %0b", $time, want.changed,
                       rsp_bus.changed);
          end
        end
        checked_total++;
        snk_gap = $urandom_range(0, snk_idle_max);
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d responses seen", cycles,
               checked_total, queued_total);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // register write, mirrored into the predictor
  task write_reg(cfg_reg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      REG_MODE:        r_mode        = mode_t'(v[1:0]);
      REG_ON_MS:       r_on_ms       = v[15:0];
      REG_OFF_MS:      r_off_ms      = v[15:0];
      REG_BLINK_LEVEL: r_blink_level = v[7:0];
      REG_FADE_START:  r_fade_start  = v[7:0];
      REG_FADE_END:    r_fade_end    = v[7:0];
      REG_FADE_MS:     r_fade_ms     = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task queue_req(logic [FUNC_W-1:0] f, logic [LEVEL_BITS-1:0] lvl);
    led_pending.push_back({f, lvl});
    queued_total++;
  endtask

  // wait for every response, then for the pipeline to empty
  task settle_requests();
    while (checked_total != queued_total) @(posedge clk);
    repeat (10) @(posedge clk);
    settings++;
  endtask

  task random_setting();
    int r, s, e;
    r = $urandom_range(0, 7);
    write_reg(REG_MODE, (r == 0) ? MODE_HOLD : (r < 3) ? MODE_BLINK :
                        (r < 5) ? MODE_FADE : MODE_PINGPONG);
    r = $urandom_range(0, 9);
    write_reg(REG_ON_MS, (r == 0) ? 32'd65535 : (r == 1) ? $urandom_range(0, 65535) :
                         $urandom_range(0, 6));
    r = $urandom_range(0, 9);
    write_reg(REG_OFF_MS, (r == 0) ? 32'd65535 : (r == 1) ? $urandom_range(0, 65535) :
                          $urandom_range(0, 6));
    r = $urandom_range(0, 7);
    write_reg(REG_BLINK_LEVEL, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(0, 255));
    // mostly narrow spans so fades reach their ends
    s = $urandom_range(0, 255);
    e = s + $urandom_range(0, 12) - 6;
    if (e < 0 || e > 255) e = s;
    if ($urandom_range(0, 5) == 0) e = $urandom_range(0, 255);
    write_reg(REG_FADE_START, s);
    write_reg(REG_FADE_END, e);
    r = $urandom_range(0, 19);
    write_reg(REG_FADE_MS, (r == 0) ? 32'hFFFF_FFFF : (r < 3) ? $urandom :
                           $urandom_range(0, 24));
  endtask

  task random_requests(int n);
    int r;
    logic [7:0] v;
    repeat (n) begin
      r = $urandom_range(0, 99);
      v = $urandom_range(0, 255);
      if (r < 44) queue_req(FUNC_TICK, v);
      else if (r < 88) queue_req(FUNC_EVAL, v);
      else if (r < 97) begin
        queue_req(FUNC_SET, v);
        // neighbor pair makes the next evaluate see a unit step
        if ($urandom_range(0, 2) == 0)
          queue_req(FUNC_SET, $urandom_range(0, 1) ? v + 8'd1 : v - 8'd1);
      end else queue_req(FUNC_NONE, v);
    end
  endtask

  // stimulus sequence
  initial begin
    int left, n;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_bus.valid     = 1'b0;
    req_bus.func      = '0;
    req_bus.set_level = '0;
    rsp_bus.ready     = 1'b0;
    led_cur  = '0;
    led_prev = '0;
    ms_now   = '0;
    ms_stamp = '0;
    r_mode        = MODE_HOLD;
    r_on_ms       = ON_MS_RST;
    r_off_ms      = OFF_MS_RST;
    r_blink_level = BLINK_LEVEL_RST;
    r_fade_start  = FADE_START_RST;
    r_fade_end    = FADE_END_RST;
    r_fade_ms     = FADE_MS_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // hold mode at reset values, unused func, level extremes
    src_idle_max = 8;
    snk_idle_max = 8;
    queue_req(FUNC_EVAL, 8'h00);
    queue_req(FUNC_NONE, 8'hFF);
    queue_req(FUNC_SET, 8'hFF);
    queue_req(FUNC_SET, 8'h00);
    queue_req(FUNC_TICK, 8'hAA);
    queue_req(FUNC_EVAL, 8'h55);
    settle_requests();

    // blink with zero on and off times
    write_reg(REG_MODE, MODE_BLINK);
    write_reg(REG_ON_MS, 32'd0);
    write_reg(REG_OFF_MS, 32'd0);
    write_reg(REG_BLINK_LEVEL, 32'd255);
    queue_req(FUNC_EVAL, 8'h00);
    queue_req(FUNC_EVAL, 8'h00);
    queue_req(FUNC_EVAL, 8'h00);
    settle_requests();

    // equal fade ends never step
    write_reg(REG_MODE, MODE_FADE);
    write_reg(REG_FADE_START, 32'd0);
    write_reg(REG_FADE_END, 32'd0);
    write_reg(REG_FADE_MS, 32'd0);
    queue_req(FUNC_SET, 8'd5);
    queue_req(FUNC_EVAL, 8'd0);
    queue_req(FUNC_EVAL, 8'd0);
    settle_requests();

    // upward step from outside the span wraps past the top
    write_reg(REG_FADE_END, 32'd10);
    queue_req(FUNC_SET, 8'd254);
    queue_req(FUNC_SET, 8'd255);
    queue_req(FUNC_EVAL, 8'd0);
    settle_requests();

    // downward step from outside the span wraps below zero
    write_reg(REG_FADE_START, 32'd10);
    write_reg(REG_FADE_END, 32'd5);
    queue_req(FUNC_SET, 8'd1);
    queue_req(FUNC_SET, 8'd0);
    queue_req(FUNC_EVAL, 8'd0);
    settle_requests();

    // ping-pong over the full downward span with the longest fade
    write_reg(REG_MODE, MODE_PINGPONG);
    write_reg(REG_FADE_START, 32'd255);
    write_reg(REG_FADE_END, 32'd0);
    write_reg(REG_FADE_MS, 32'hFFFF_FFFF);
    queue_req(FUNC_SET, 8'd7);
    queue_req(FUNC_EVAL, 8'd0);
    queue_req(FUNC_EVAL, 8'd0);
    settle_requests();

    // longest blink times
    write_reg(REG_MODE, MODE_BLINK);
    write_reg(REG_ON_MS, 32'd65535);
    write_reg(REG_OFF_MS, 32'd65535);
    queue_req(FUNC_TICK, 8'd0);
    queue_req(FUNC_EVAL, 8'd0);
    settle_requests();

    // random phases, each with its own register setting and pacing
    left = RANDOM_REQUESTS;
    while (left > 0) begin
      random_setting();
      src_idle_max = $urandom_range(0, 1) * 8;
      snk_idle_max = $urandom_range(0, 1) * 8;
      n = $urandom_range(60, 140);
      if (n > left) n = left;
      random_requests(n);
      left -= n;
      settle_requests();
    end

    $display("checked %0d requests over %0d register settings", checked_total, settings);
    $display("%0d level writes predicted, %0d cycles", level_writes, cycles);
    if (errors == 0 && led_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
